FILE: design/mte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants for the track event encoder: byte codes of the
// track stream and the frame that carries one item's bytes to the serializer.
// ----------------------------------------------------------------------------
package mte_pkg;

   // item kinds
   localparam logic REQ_CHANNEL_EVENT = 1'b0;
   localparam logic REQ_END_OF_TRACK  = 1'b1;

   // byte codes
   localparam logic [7:0] VLQ_CONT      = 8'h80;
   localparam logic [7:0] META_MARK     = 8'hFF;
   localparam logic [7:0] META_END_TYPE = 8'h2F;
   localparam logic [7:0] ZERO_BYTE     = 8'h00;

   // longest frame of one item
   localparam int FRAME_BYTES = 8;
   localparam int IDX_W       = $clog2(FRAME_BYTES);

   // bytes of one item, byte 0 goes out first
   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] bytes;
      logic [IDX_W-1:0]            last_idx;
   } frame_type;

endpackage
`default_nettype wire

FILE: design/midi_track_event_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_encoder_top
// Turns timed channel events into track bytes: delta time as a variable-length
// quantity, then status and data bytes; end-of-track writes the meta event.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_ready | type, time, kind, channel, data
//  rsp_    | out       | rsp_valid / rsp_ready | out_byte, last_byte
//
//  An item is taken into an input register, framed in one pass and handed to
//  the serializer, which sends one byte per cycle while rsp_ready is high:
//  4 to 8 bytes per item (1 to 5 delta bytes plus 3).
//  The input register takes the next item while the current frame drains.
//  Synchronous reset clears the valid flags and the stored time.
//  A stalled result holds its byte; the input stalls while its register is full and the serializer is busy.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [31:0] req_event_time,
   input  wire logic [3:0]  req_event_kind,
   input  wire logic [3:0]  req_channel,
   input  wire logic [7:0]  req_data_first,
   input  wire logic [7:0]  req_data_second,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte
);

   logic        item_valid_ff, item_valid_in;
   logic        type_ff;
   logic [31:0] time_ff;
   logic [3:0]  kind_ff;
   logic [3:0]  chan_ff;
   logic [7:0]  first_ff;
   logic [7:0]  second_ff;
   logic [31:0] prev_time_ff, prev_time_in;
   logic        ser_free;
   logic        load;
   logic        req_take;
   mte_pkg::frame_type frame;

   // handshake between input register and serializer
   assign load      = item_valid_ff && ser_free;
   assign req_ready = !item_valid_ff || load;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (load) begin
         item_valid_in = 1'b0;
      end
   end

   // stored time follows each framed item; end-of-track clears it
   always_comb begin
      prev_time_in = prev_time_ff;
      if (load) begin
         prev_time_in = (type_ff == mte_pkg::REQ_END_OF_TRACK) ? 32'd0 : time_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         prev_time_ff  <= 32'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         prev_time_ff  <= prev_time_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff   <= req_type;
         time_ff   <= req_event_time;
         kind_ff   <= req_event_kind;
         chan_ff   <= req_channel;
         first_ff  <= req_data_first;
         second_ff <= req_data_second;
      end
   end

   mte_frame_build u_frame_build (
      .item_type     (type_ff),
      .event_time    (time_ff),
      .event_kind    (kind_ff),
      .channel       (chan_ff),
      .data_first    (first_ff),
      .data_second   (second_ff),
      .previous_time (prev_time_ff),
      .frame         (frame)
   );

   mte_byte_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .frame         (frame),
      .free          (ser_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
`default_nettype wire

FILE: design/mte_frame_build.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_frame_build
// Forms the delta time, encodes it as a variable-length quantity and packs it
// with the status and data bytes (or the end-of-track meta event) into a frame.
// ----------------------------------------------------------------------------
module mte_frame_build (
   input  wire logic              item_type,
   input  wire logic [31:0]       event_time,
   input  wire logic [3:0]        event_kind,
   input  wire logic [3:0]        channel,
   input  wire logic [7:0]        data_first,
   input  wire logic [7:0]        data_second,
   input  wire logic [31:0]       previous_time,
   output mte_pkg::frame_type     frame
);

   logic [31:0] delta;
   logic [7:0]  g0, g1, g2, g3, g4;
   logic [7:0]  status;
   logic [2:0]  vlq_len;

   // delta wraps modulo 2^32
   assign delta  = event_time - previous_time;
   assign status = {event_kind, channel};

   // 7-bit groups, least significant first
   assign g0 = {1'b0, delta[6:0]};
   assign g1 = {1'b0, delta[13:7]};
   assign g2 = {1'b0, delta[20:14]};
   assign g3 = {1'b0, delta[27:21]};
   assign g4 = {4'b0, delta[31:28]};

   // number of groups needed
   always_comb begin
      if (delta[31:28] != 4'b0) begin
         vlq_len = 3'd5;
      end else if (delta[27:21] != 7'b0) begin
         vlq_len = 3'd4;
      end else if (delta[20:14] != 7'b0) begin
         vlq_len = 3'd3;
      end else if (delta[13:7] != 7'b0) begin
         vlq_len = 3'd2;
      end else begin
         vlq_len = 3'd1;
      end
   end

   // frame packing, most significant group first
   always_comb begin
      frame.bytes    = '0;
      frame.last_idx = mte_pkg::IDX_W'(3);
      if (item_type == mte_pkg::REQ_END_OF_TRACK) begin
         frame.bytes[0] = mte_pkg::ZERO_BYTE;
         frame.bytes[1] = mte_pkg::META_MARK;
         frame.bytes[2] = mte_pkg::META_END_TYPE;
         frame.bytes[3] = mte_pkg::ZERO_BYTE;
      end else begin
         unique case (vlq_len)
            3'd1: begin
               frame.bytes[0] = g0;
               frame.bytes[1] = status;
               frame.bytes[2] = data_first;
               frame.bytes[3] = data_second;
            end
            3'd2: begin
               frame.bytes[0] = g1 | mte_pkg::VLQ_CONT;
               frame.bytes[1] = g0;
               frame.bytes[2] = status;
               frame.bytes[3] = data_first;
               frame.bytes[4] = data_second;
            end
            3'd3: begin
               frame.bytes[0] = g2 | mte_pkg::VLQ_CONT;
               frame.bytes[1] = g1 | mte_pkg::VLQ_CONT;
               frame.bytes[2] = g0;
               frame.bytes[3] = status;
               frame.bytes[4] = data_first;
               frame.bytes[5] = data_second;
            end
            3'd4: begin
               frame.bytes[0] = g3 | mte_pkg::VLQ_CONT;
               frame.bytes[1] = g2 | mte_pkg::VLQ_CONT;
               frame.bytes[2] = g1 | mte_pkg::VLQ_CONT;
               frame.bytes[3] = g0;
               frame.bytes[4] = status;
               frame.bytes[5] = data_first;
               frame.bytes[6] = data_second;
            end
            default: begin
               frame.bytes[0] = g4 | mte_pkg::VLQ_CONT;
               frame.bytes[1] = g3 | mte_pkg::VLQ_CONT;
               frame.bytes[2] = g2 | mte_pkg::VLQ_CONT;
               frame.bytes[3] = g1 | mte_pkg::VLQ_CONT;
               frame.bytes[4] = g0;
               frame.bytes[5] = status;
               frame.bytes[6] = data_first;
               frame.bytes[7] = data_second;
            end
         endcase
         frame.last_idx = mte_pkg::IDX_W'(vlq_len + 3'd2);
      end
   end

endmodule
`default_nettype wire

FILE: design/mte_byte_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_byte_serializer
// Holds one frame and shifts its bytes out one per accepted result item,
// flagging the final byte; reports when a new frame may be loaded.
// ----------------------------------------------------------------------------
module mte_byte_serializer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire mte_pkg::frame_type frame,
   output logic                    free,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_byte
);

   logic                                    valid_ff, valid_in;
   logic [mte_pkg::FRAME_BYTES-1:0][7:0]    bytes_ff, bytes_in;
   logic [mte_pkg::IDX_W-1:0]               remain_ff, remain_in;
   logic                                    last;
   logic                                    take;

   assign last = (remain_ff == '0);
   assign take = valid_ff && rsp_ready;
   assign free = !valid_ff || (take && last);

   // load a new frame or shift to the next byte
   always_comb begin
      valid_in  = valid_ff;
      bytes_in  = bytes_ff;
      remain_in = remain_ff;
      if (load) begin
         valid_in  = 1'b1;
         bytes_in  = frame.bytes;
         remain_in = frame.last_idx;
      end else if (take) begin
         valid_in  = !last;
         bytes_in  = bytes_ff >> 8;
         remain_in = remain_ff - 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      bytes_ff  <= bytes_in;
      remain_ff <= remain_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = bytes_ff[0];
   assign rsp_last_byte = last;

endmodule
`default_nettype wire

FILE: design/mte_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_checker
// Port-level checks on the track event encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mte_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_byte
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last_byte))
      else $error("stalled result item changed");

   // nothing pending after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with no result pending the input is always open
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

   // an accepted item reaches the result through the input register and the serializer when drained
   a_item_reaches_output: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("accepted item produced no result");

endmodule

bind midi_track_event_encoder_top mte_checker u_mte_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);
`default_nettype wire
